[design/humidity_temperature_compensation_defines.svh]
// Shared assertion macros for the humidity/temperature compensation block.
// Each macro expects clk and arst_n in scope.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HTC_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define HTC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[design/htc_pkg.sv]
`default_nettype none

package htc_pkg;

	// Pipeline depth: offset add, products, sum, classify, divide
	localparam int STAGES = 5;

	// Configuration
	localparam logic signed [13:0] OFFSET_RESET = -14'sd4400;

	// Temperature path
	localparam logic signed [17:0] TEMP_BIAS        = 18'sd2500;
	localparam logic signed [17:0] TEMP_HALF        = 18'sd50;
	localparam int                 TEMP_RECIP_SHIFT = 24;
	// ceil(2^24 / 100): exact quotient for dividends below 199728
	localparam logic [17:0]        TEMP_RECIP       = 18'd167773;
	localparam int                 TEMP_Q_W         = 10;

	// Humidity path, law scaled by 10^7
	localparam logic [19:0]        HUM_GAIN_BASE    = 20'd1000;
	localparam logic [18:0]        HUM_LIN          = 19'd405000;
	localparam logic [39:0]        HUM_BIAS         = 40'd40000000;
	localparam logic [39:0]        HUM_HALF         = 40'd5000000;
	localparam logic signed [39:0] HUM_FULL         = 40'sd1000000000;
	localparam int                 HUM_PRESHIFT     = 7;
	localparam int                 HUM_RECIP_SHIFT  = 40;
	// ceil(2^40 / 78125); 10^7 = 2^7 * 78125
	localparam logic [23:0]        HUM_RECIP        = 24'd14073749;
	localparam logic [6:0]         HUM_MAX          = 7'd100;

	// Result selection for one item
	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_RAW,
		MODE_CALC
	} mode_t;

	// Humidity range class after the law
	typedef enum logic [1:0] {
		HUM_LOW,
		HUM_MID,
		HUM_HIGH
	} hum_cls_t;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
		logic        measure_error;
	} sample_t;

	typedef struct packed {
		logic signed [16:0] temperature_out;
		logic [15:0]        humidity_out;
	} result_t;

	// Per-stage load enables and valid bits
	typedef struct packed {
		logic [STAGES-1:0] en;
		logic [STAGES-1:0] v;
	} htc_ctl_t;

	// Front half output (stage 3)
	typedef struct packed {
		logic signed [39:0]    n;
		logic                  tpos;
		logic [TEMP_Q_W-1:0]   tq;
		logic [15:0]           raw_temperature;
		logic [15:0]           raw_humidity;
		mode_t                 mode;
	} poly_t;

endpackage

`default_nettype wire

[design/humidity_temperature_compensation.sv]
// Humidity / temperature compensation
//
// sample channel (sample_valid / sample_ready / sample): one raw reading per
// item: raw temperature word, raw humidity word, measurement error flag.
// result channel (result_valid / result_ready / result): whole degrees C and
// whole percent RH; raw words pass through when the error flag is set, and
// a zero humidity word gives zero for both.
// cfg_we / cfg_wdata: writes the signed temperature offset in 0.01 degree.
//
// The pipeline has five register stages. Throughput is one item per cycle
// while result_ready is high, set by the five-stage pipeline (offset add,
// multiplies, law sum, clamp, reciprocal divide).
// Reset empties the pipeline and loads an offset of -44.00 degrees.
// When result_ready is low the items hold in their stages; empty stages
// still fill, and sample_ready drops only once all five stages hold items.
`default_nettype none

module humidity_temperature_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  htc_pkg::sample_t   sample,
	output logic               result_valid,
	input  logic               result_ready,
	output htc_pkg::result_t   result,
	input  logic               cfg_we,
	input  logic signed [13:0] cfg_wdata
);
	import htc_pkg::*;

	logic signed [13:0] offset_q;
	htc_ctl_t           ctl;
	poly_t              poly;

	// Temperature offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	htc_pipe_ctl u_ctl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.result_ready (result_ready),
		.ctl          (ctl)
	);

	htc_poly u_poly (
		.clk    (clk),
		.ctl    (ctl),
		.sample (sample),
		.offset (offset_q),
		.poly   (poly)
	);

	htc_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.poly   (poly),
		.result (result)
	);

	assign sample_ready = ctl.en[0];
	assign result_valid = ctl.v[STAGES-1];

endmodule

`default_nettype wire

[design/htc_pipe_ctl.sv]
`default_nettype none
`include "humidity_temperature_compensation_defines.svh"

module htc_pipe_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	input  logic             result_ready,
	output htc_pkg::htc_ctl_t ctl
);
	import htc_pkg::*;

	logic [STAGES-1:0] v_q;
	logic [STAGES-1:0] en;

	// A stage loads when empty or when its item moves on
	always_comb begin
		en[STAGES-1] = !v_q[STAGES-1] || result_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	// Valid bits follow the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= sample_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign ctl.en = en;
	assign ctl.v  = v_q;

	`HTC_ASSERT_NOW(a_ready_chain, result_ready, &en, "output ready must open every stage")
	`HTC_ASSERT_NEXT(a_hold_last, v_q[STAGES-1] && !result_ready, v_q[STAGES-1],
		"stalled result item was dropped")

endmodule

`default_nettype wire

[design/htc_poly.sv]
`default_nettype none

module htc_poly (
	input  logic               clk,
	input  htc_pkg::htc_ctl_t  ctl,
	input  htc_pkg::sample_t   sample,
	input  logic signed [13:0] offset,
	output htc_pkg::poly_t     poly
);
	import htc_pkg::*;

	// Stage 1: offset add, linear gain
	logic signed [17:0] tc_c, dt_c;
	logic [19:0]        gain_c;
	mode_t              mode_c;

	logic signed [17:0] tc_s1, dt_s1;
	logic [19:0]        gain_s1;
	logic [15:0]        rt_s1, rh_s1;
	mode_t              mode_s1;

	assign tc_c   = $signed({2'b00, sample.raw_temperature}) + 18'(offset);
	assign dt_c   = tc_c - TEMP_BIAS;
	assign gain_c = HUM_GAIN_BASE + {1'b0, sample.raw_humidity, 3'b000};

	// Zero humidity word wins over the error flag
	always_comb begin
		priority if (sample.raw_humidity == 16'd0) begin
			mode_c = MODE_ZERO;
		end else if (sample.measure_error) begin
			mode_c = MODE_RAW;
		end else begin
			mode_c = MODE_CALC;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			tc_s1   <= tc_c;
			dt_s1   <= dt_c;
			gain_s1 <= gain_c;
			rt_s1   <= sample.raw_temperature;
			rh_s1   <= sample.raw_humidity;
			mode_s1 <= mode_c;
		end
	end

	// Stage 2: products, temperature magnitude
	logic signed [38:0] p1_c;
	logic [31:0]        sq_c;
	logic [34:0]        lin_c;
	logic               tpos_c;
	logic [16:0]        tmag_c;

	logic signed [38:0] p1_s2;
	logic [31:0]        sq_s2;
	logic [34:0]        lin_s2;
	logic               tpos_s2;
	logic [16:0]        tmag_s2;
	logic [15:0]        rt_s2, rh_s2;
	mode_t              mode_s2;

	assign p1_c   = 39'(dt_s1) * 39'($signed({1'b0, gain_s1}));
	assign sq_c   = 32'(rh_s1) * 32'(rh_s1);
	assign lin_c  = 35'(rh_s1) * 35'(HUM_LIN);
	assign tpos_c = tc_s1 > 18'sd0;
	assign tmag_c = tpos_c ? 17'(tc_s1 + TEMP_HALF) : 17'(-tc_s1);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			p1_s2   <= p1_c;
			sq_s2   <= sq_c;
			lin_s2  <= lin_c;
			tpos_s2 <= tpos_c;
			tmag_s2 <= tmag_c;
			rt_s2   <= rt_s1;
			rh_s2   <= rh_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: law sum, temperature reciprocal multiply
	logic [39:0] n_c;
	logic [34:0] tprod_c;
	poly_t       poly_s3;

	// 28*s^2 = 32*s^2 - 4*s^2
	assign n_c = 40'(p1_s2) - 40'({sq_s2, 5'b00000}) + 40'({sq_s2, 2'b00})
		+ 40'(lin_s2) - HUM_BIAS;
	assign tprod_c = 35'(tmag_s2) * 35'(TEMP_RECIP);

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			poly_s3.n               <= $signed(n_c);
			poly_s3.tpos            <= tpos_s2;
			poly_s3.tq              <= tprod_c[TEMP_RECIP_SHIFT +: TEMP_Q_W];
			poly_s3.raw_temperature <= rt_s2;
			poly_s3.raw_humidity    <= rh_s2;
			poly_s3.mode            <= mode_s2;
		end
	end

	assign poly = poly_s3;

endmodule

`default_nettype wire

[design/htc_round.sv]
`default_nettype none
`include "humidity_temperature_compensation_defines.svh"

module htc_round (
	input  logic              clk,
	input  logic              arst_n,
	input  htc_pkg::htc_ctl_t ctl,
	input  htc_pkg::poly_t    poly,
	output htc_pkg::result_t  result
);
	import htc_pkg::*;

	// Stage 4: clamp class, round bias, signed temperature
	logic [39:0]        m_c;
	hum_cls_t           hcls_c;
	logic signed [16:0] tval_c;

	hum_cls_t           hcls_s4;
	logic [22:0]        x_s4;
	logic signed [16:0] tval_s4;
	logic [15:0]        rt_s4, rh_s4;
	mode_t              mode_s4;

	assign m_c = $unsigned(poly.n) + HUM_HALF;

	always_comb begin
		priority if (poly.n[39] || poly.n == 40'sd0) begin
			hcls_c = HUM_LOW;
		end else if (poly.n >= HUM_FULL) begin
			hcls_c = HUM_HIGH;
		end else begin
			hcls_c = HUM_MID;
		end
	end

	assign tval_c = poly.tpos ? $signed({7'd0, poly.tq}) : -$signed({7'd0, poly.tq});

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			hcls_s4 <= hcls_c;
			x_s4    <= m_c[HUM_PRESHIFT +: 23];
			tval_s4 <= tval_c;
			rt_s4   <= poly.raw_temperature;
			rh_s4   <= poly.raw_humidity;
			mode_s4 <= poly.mode;
		end
	end

	// Stage 5: divide by 78125 via reciprocal, final select
	logic [46:0] hprod_c;
	logic [6:0]  hq_c;
	logic [6:0]  hum_c;
	result_t     res_c;
	result_t     res_s5;

	assign hprod_c = 47'(x_s4) * 47'(HUM_RECIP);
	assign hq_c    = hprod_c[HUM_RECIP_SHIFT +: 7];

	always_comb begin
		unique case (hcls_s4)
			HUM_LOW:  hum_c = 7'd0;
			HUM_MID:  hum_c = hq_c;
			HUM_HIGH: hum_c = HUM_MAX;
			default:  hum_c = 7'd0;
		endcase
	end

	always_comb begin
		unique case (mode_s4)
			MODE_ZERO: begin
				res_c.temperature_out = '0;
				res_c.humidity_out    = '0;
			end
			MODE_RAW: begin
				res_c.temperature_out = $signed({1'b0, rt_s4});
				res_c.humidity_out    = rh_s4;
			end
			MODE_CALC: begin
				res_c.temperature_out = tval_s4;
				res_c.humidity_out    = 16'(hum_c);
			end
			default: begin
				res_c.temperature_out = '0;
				res_c.humidity_out    = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			res_s5 <= res_c;
		end
	end

	assign result = res_s5;

	`HTC_ASSERT_NEXT(a_hum_range, ctl.en[4] && ctl.v[3] && mode_s4 == MODE_CALC,
		res_s5.humidity_out <= 16'(HUM_MAX), "computed humidity above 100")
	`HTC_ASSERT_NEXT(a_temp_range, ctl.en[4] && ctl.v[3] && mode_s4 == MODE_CALC,
		res_s5.temperature_out >= -17'sd82 && res_s5.temperature_out <= 17'sd737,
		"computed temperature out of range")

endmodule

`default_nettype wire
